[sv/kdp_pkg.sv]
package kdp_pkg;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned BEST_W   = 32;
  localparam int unsigned CAP_W    = 8;

  // Front-to-back queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified object, as queued between front and back
  typedef struct packed {
    logic                start;  // clear the row before this object
    logic                heavy;  // weight beyond the row, no update
    logic [WEIGHT_W-1:0] weight;
    logic [VALUE_W-1:0]  value;
  } kdp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } kdp_state_t;

endpackage

[sv/kdp_ram.sv]
module kdp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

[sv/kdp_front.sv]
module kdp_front #(
  parameter int unsigned MAX_CAPACITY = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               init_busy,
  output logic               q_valid,
  output kdp_pkg::kdp_item_t q_item,
  input  logic               q_pop
);

  import kdp_pkg::*;

  kdp_item_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  kdp_item_t           cls_item;

  // Hold off new objects while the row is being cleared after reset
  assign in_tready = (count_r != QCNT_W'(QDEPTH)) && !init_busy;
  assign push      = in_tvalid && in_tready;

  // Classify: an object heavier than the whole row never updates anything
  always_comb begin
    cls_item.start  = in_tuser;
    cls_item.weight = in_tdata[WEIGHT_W-1:0];
    cls_item.value  = in_tdata[WEIGHT_W +: VALUE_W];
    cls_item.heavy  = in_tdata[WEIGHT_W-1:0] > WEIGHT_W'(MAX_CAPACITY);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

endmodule

[sv/kdp_back.sv]
module kdp_back #(
  parameter int unsigned MAX_CAPACITY = 255
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  kdp_pkg::kdp_item_t                    q_item,
  output logic                                  q_pop,
  input  logic [$clog2(MAX_CAPACITY+1)-1:0]     cap_idx,
  output logic                                  init_busy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kdp_pkg::BEST_W-1:0]            out_best,
  output logic                                  out_ovf
);

  import kdp_pkg::*;

  localparam int unsigned DEPTH = MAX_CAPACITY + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] XMAX = AW'(MAX_CAPACITY);

  kdp_state_t         state_r, state_nxt;
  logic [AW-1:0]      x_r, x_nxt;
  logic [AW-1:0]      w_r, w_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               clear_r, clear_nxt;
  logic               heavy_r, heavy_nxt;
  logic               init_r, init_nxt;
  logic               ovf_r, ovf_nxt;
  logic [BEST_W-1:0]  res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BEST_W-1:0]  out_best_r, out_best_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // read stage
  logic               s1_valid_r;
  logic [AW-1:0]      s1_x_r;
  logic               s1_use_r;

  logic               use_now;
  logic [AW-1:0]      raddr_b;
  logic [BEST_W-1:0]  rdata_a, rdata_b;
  logic [BEST_W-1:0]  keep, src, take, new_val;
  logic [BEST_W:0]    sum;

  assign use_now = !heavy_r && (x_r >= w_r);
  assign raddr_b = use_now ? x_r - w_r : x_r;

  kdp_ram #(
    .WIDTH (BEST_W),
    .DEPTH (DEPTH)
  ) u_row (
    .clk     (clk),
    .we      (s1_valid_r),
    .waddr   (s1_x_r),
    .wdata   (new_val),
    .raddr_a (x_r),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Update: a clearing sweep sees the old row as all zeros
  always_comb begin
    keep    = clear_r ? '0 : rdata_a;
    src     = clear_r ? '0 : rdata_b;
    sum     = {1'b0, src} + (BEST_W+1)'(value_r);
    take    = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
    new_val = (s1_use_r && (take > keep)) ? take : keep;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    value_nxt     = value_r;
    clear_nxt     = clear_r;
    heavy_nxt     = heavy_r;
    init_nxt      = init_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_best_nxt  = out_best_r;
    out_ovf_nxt   = out_ovf_r;
    q_pop         = 1'b0;

    if (s1_valid_r && s1_use_r && sum[BEST_W]) begin
      ovf_nxt = 1'b1;
    end
    if (s1_valid_r && (s1_x_r == cap_idx)) begin
      res_nxt = new_val;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          w_nxt     = q_item.weight[AW-1:0];
          heavy_nxt = q_item.heavy;
          clear_nxt = q_item.start;
          value_nxt = q_item.value;
          x_nxt     = XMAX;
          if (q_item.start) begin
            ovf_nxt = 1'b0;
          end
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (x_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          x_nxt = x_r - 1'b1;
        end
      end
      ST_DRAIN: begin
        // last write lands now; next sweep may read the same entry
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_best_nxt  = res_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      x_r         <= XMAX;
      clear_r     <= 1'b1;
      heavy_r     <= 1'b1;
      init_r      <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      clear_r     <= clear_nxt;
      heavy_r     <= heavy_nxt;
      init_r      <= init_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      s1_valid_r  <= (state_r == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    value_r    <= value_nxt;
    res_r      <= res_nxt;
    out_best_r <= out_best_nxt;
    out_ovf_r  <= out_ovf_nxt;
    s1_x_r     <= x_r;
    s1_use_r   <= use_now;
  end

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_best  = out_best_r;
  assign out_ovf   = out_ovf_r;

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    x_r <= XMAX)
    else $error("sweep index beyond row");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) && (x_r == '0) |=> (state_r == ST_DRAIN) && s1_valid_r)
    else $error("sweep did not drain after entry zero");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !out_valid_r && !q_pop)
    else $error("activity during clearing pass");

  a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.start |=> !ovf_r)
    else $error("overflow flag not cleared at set start");

endmodule

[sv/knapsack_dp_row_update.sv]
// 0/1 knapsack row engine. Each input transaction carries one object; the
// block keeps one row of best total values per capacity 0..MAX_CAPACITY in
// a RAM and updates it in place, highest capacity first, for every object.
//
// Channels: in_* takes objects (tuser = start of a new set, which clears the
// row and the overflow flag first). out_* returns one transaction per object:
// the best value at min(capacity, MAX_CAPACITY) and a sticky overflow flag.
// cfg_wr_en/cfg_wr_data write the capacity register; write it only when idle.
//
// Per object: a sweep over all MAX_CAPACITY+1 row entries through the RAM
// read ports, one entry per cycle, then pipeline drain and result load.
// A two-entry queue sits between the input side and the sweep engine, so
// up to two objects can wait while one is swept and one result waits.
//
// Reset: a clearing pass writes zeros into all MAX_CAPACITY+1 entries,
// with in_tready low until it ends.
// Stall: the result stays in its output register while out_tready is low;
// the engine holds its finished sweep until that register frees up.
module knapsack_dp_row_update #(
  parameter int unsigned MAX_CAPACITY = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] item_weight, [31:16] item_value
  input  logic        in_tuser,   // [0] start_set
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] best_value
  output logic        out_tuser,  // [0] overflow
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data // [7:0] capacity
);

  import kdp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned CW = (AW > CAP_W) ? AW : CAP_W;

  logic [CAP_W-1:0] capacity_r;
  logic [AW-1:0]    cap_idx;
  logic             init_busy;
  logic             q_valid;
  logic             q_pop;
  kdp_item_t        q_item;

  // Capacity register, reset to full range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '1;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // Capacity beyond the row reads the last entry
  assign cap_idx = (CW'(capacity_r) > CW'(MAX_CAPACITY)) ? AW'(MAX_CAPACITY)
                                                         : AW'(capacity_r);

  kdp_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  kdp_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cap_idx   (cap_idx),
    .init_busy (init_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_best  (out_tdata),
    .out_ovf   (out_tuser)
  );

endmodule
